@@ rtl/ese_pkg.sv @@
// encoder speed estimator package: widths, reset values, register indexes
// no dependencies
package ese_pkg;
    localparam int POSITION_BITS_DEF = 14;
    localparam int TIME_BITS_DEF     = 24;
    localparam logic [30:0] JUMP_RESET     = 31'd256000;
    localparam logic [16:0] GAIN_RESET     = 17'd6554;
    localparam logic [15:0] DEADBAND_RESET = 16'd26;
    localparam logic [33:0] RPM_SCALE      = 34'd15360000000;
    localparam logic [1:0] REG_JUMP = 2'd0;
    localparam logic [1:0] REG_GAIN = 2'd1;
    localparam logic [1:0] REG_DEADBAND = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_DIV, ST_SAT, ST_LIMIT, ST_FILT, ST_DONE
    } back_state_t;
endpackage

@@ rtl/ese_front.sv @@
// front: accepts a word, classifies the zero interval, holds a one-entry queue
// depends on ese_pkg
module ese_front #(
    parameter int POSITION_BITS = ese_pkg::POSITION_BITS_DEF,
    parameter int TIME_BITS = ese_pkg::TIME_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [POSITION_BITS-1:0] s_angle_code,
    input  logic [TIME_BITS-1:0]     s_elapsed_us,
    output logic                     q_valid,
    input  logic                     q_ready,
    output logic [POSITION_BITS-1:0] q_angle,
    output logic [TIME_BITS-1:0]     q_dt,
    output logic                     q_bad
);
    import ese_pkg::*;
    logic                     valid_reg;
    logic [POSITION_BITS-1:0] angle_reg;
    logic [TIME_BITS-1:0]     dt_reg;
    logic                     bad_reg;

    assign s_ready = !valid_reg || q_ready;
    assign q_valid = valid_reg;
    assign q_angle = angle_reg;
    assign q_dt    = dt_reg;
    assign q_bad   = bad_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            angle_reg <= s_angle_code;
            dt_reg    <= s_elapsed_us;
            bad_reg   <= (s_elapsed_us == '0);
        end
    end
endmodule

@@ rtl/ese_back.sv @@
// back: speed conversion with a bit-serial divider, spike limit, iir, deadband
// depends on ese_pkg
module ese_back #(
    parameter int POSITION_BITS = ese_pkg::POSITION_BITS_DEF,
    parameter int TIME_BITS = ese_pkg::TIME_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     q_valid,
    output logic                     q_ready,
    input  logic [POSITION_BITS-1:0] q_angle,
    input  logic [TIME_BITS-1:0]     q_dt,
    input  logic                     q_bad,
    input  logic [30:0]              max_speed_jump,
    input  logic [16:0]              filter_gain,
    input  logic [15:0]              zero_deadband,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [31:0]       m_speed_rpm,
    output logic                     m_spike_limited,
    output logic                     m_bad_interval
);
    import ese_pkg::*;
    localparam int MAG_BITS = POSITION_BITS;
    localparam int NUM_BITS = 34 + MAG_BITS;
    localparam int DEN_BITS = TIME_BITS + POSITION_BITS;
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    back_state_t state_reg, state_next;
    logic [POSITION_BITS-1:0] last_pos_reg;
    logic signed [31:0]       last_speed_reg, filt_reg;
    logic [POSITION_BITS-1:0] pos_reg;
    logic                     neg_reg;
    logic [NUM_BITS-1:0]      num_reg;
    logic [DEN_BITS-1:0]      den_reg;
    logic [DEN_BITS:0]        rem_reg;
    logic [NUM_BITS-1:0]      quo_reg;
    logic [CNT_BITS-1:0]      cnt_reg;
    logic signed [32:0]       inst_reg;
    logic                     lim_reg;
    logic signed [33:0]       diff_reg;
    logic signed [51:0]       prod_reg;
    logic                     out_valid_reg;
    logic signed [31:0]       out_speed_reg;
    logic                     out_lim_reg, out_bad_reg;

    logic [POSITION_BITS-1:0] d;
    logic                     dneg;
    logic [POSITION_BITS-1:0] mag;
    logic [DEN_BITS:0]        rem_sh;
    logic [NUM_BITS-1:0]      q_r;
    logic signed [33:0]       delta;
    logic [33:0]              absd, stp;
    logic signed [33:0]       lim_val;
    logic [16:0]              g;
    logic signed [63:0]       acc;
    logic signed [47:0]       filt_full;
    logic signed [31:0]       filt_w;
    logic [31:0]              filt_abs;

    assign q_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_speed_rpm = out_speed_reg;
    assign m_spike_limited = out_lim_reg;
    assign m_bad_interval = out_bad_reg;

    always_comb begin
        d    = q_angle - last_pos_reg;
        dneg = d[POSITION_BITS-1];
        mag  = dneg ? (~d + 1'b1) : d;
        rem_sh = {rem_reg[DEN_BITS-1:0], num_reg[NUM_BITS-1]};
        // round: quotient of (num + den/2) / den done by pre-adding
        q_r = quo_reg;
        delta = 34'(inst_reg) - 34'(last_speed_reg);
        absd  = delta[33] ? 34'(-delta) : 34'(delta);
        stp   = (absd >> 1) > {3'b0, max_speed_jump} ? {3'b0, max_speed_jump}
                                                     : (absd >> 1);
        lim_val = delta[33] ? 34'(last_speed_reg) - 34'(stp)
                            : 34'(last_speed_reg) + 34'(stp);
        g = filter_gain > 17'd65536 ? 17'd65536 : filter_gain;
        acc = (64'(filt_reg) <<< 16) + 64'(prod_reg) + 64'sd32768;
        filt_full = 48'(acc >>> 16);
        filt_w = filt_full[31:0];
        filt_abs = filt_w[31] ? 32'(-filt_w) : 32'(filt_w);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (q_valid && q_ready) state_next = q_bad ? ST_DONE : ST_MUL;
            ST_MUL:   state_next = ST_DIV;
            ST_DIV:   if (cnt_reg == '0) state_next = ST_SAT;
            ST_SAT:   state_next = ST_LIMIT;
            ST_LIMIT: state_next = ST_FILT;
            ST_FILT:  state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            last_pos_reg   <= '0;
            last_speed_reg <= '0;
            filt_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: if (q_valid && q_ready) begin
                    pos_reg <= q_angle;
                    neg_reg <= dneg;
                    den_reg <= DEN_BITS'(q_dt) << POSITION_BITS;
                    num_reg <= NUM_BITS'(mag);
                    out_bad_reg <= q_bad;
                    lim_reg <= 1'b0;
                end
                ST_MUL: begin
                    // one 34 x POSITION_BITS product, then add den/2 for rounding
                    num_reg <= NUM_BITS'(num_reg[MAG_BITS-1:0] * RPM_SCALE)
                               + NUM_BITS'(den_reg >> 1);
                    rem_reg <= '0;
                    quo_reg <= '0;
                    cnt_reg <= CNT_BITS'(NUM_BITS);
                end
                ST_DIV: if (cnt_reg != '0) begin
                    if (rem_sh >= {1'b0, den_reg}) begin
                        rem_reg <= rem_sh - {1'b0, den_reg};
                        quo_reg <= {quo_reg[NUM_BITS-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[NUM_BITS-2:0], 1'b0};
                    end
                    num_reg <= num_reg << 1;
                    cnt_reg <= cnt_reg - 1'b1;
                end
                ST_SAT: begin
                    if (neg_reg)
                        inst_reg <= (q_r > NUM_BITS'(64'd2147483648)) ? -33'sd2147483648
                                    : -$signed({1'b0, q_r[31:0]});
                    else
                        inst_reg <= (q_r > NUM_BITS'(64'd2147483647)) ? 33'sd2147483647
                                    : $signed({1'b0, q_r[31:0]});
                end
                ST_LIMIT: begin
                    if (absd > {3'b0, max_speed_jump}) begin
                        inst_reg <= 33'(lim_val);
                        lim_reg  <= 1'b1;
                        diff_reg <= lim_val - 34'(filt_reg);
                    end else begin
                        diff_reg <= 34'(inst_reg) - 34'(filt_reg);
                    end
                end
                ST_FILT: begin
                    prod_reg <= 52'(diff_reg * $signed({1'b0, g}));
                end
                ST_DONE: begin
                    out_valid_reg <= 1'b1;
                    if (out_bad_reg) begin
                        out_speed_reg <= filt_reg;
                        out_lim_reg   <= 1'b0;
                    end else begin
                        out_lim_reg    <= lim_reg;
                        out_speed_reg  <= (filt_abs < 32'(zero_deadband)) ? '0 : filt_w;
                        filt_reg       <= (filt_abs < 32'(zero_deadband)) ? '0 : filt_w;
                        last_speed_reg <= inst_reg[31:0];
                        last_pos_reg   <= pos_reg;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

@@ rtl/encoder_speed_estimator_top.sv @@
// encoder speed estimator top level: register port and front/back wiring
// depends on ese_pkg, ese_front, ese_back
// A word passes from its input handshake through the front queue to the back
// end, which forms the product, runs a bit-serial divider that retires one of
// 34 + POSITION_BITS quotient bits a cycle, then does the exit check,
// saturation, the spike limit, the filter product and the output. A zero
// interval skips the divider and goes straight to the output.
// The front holds one word, so the next word is taken while the back works;
// the back takes it once the previous result has been taken. Registers are
// written on cfg_*.
module encoder_speed_estimator_top #(
    parameter int POSITION_BITS = ese_pkg::POSITION_BITS_DEF,
    parameter int TIME_BITS = ese_pkg::TIME_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [POSITION_BITS-1:0] s_angle_code,
    input  logic [TIME_BITS-1:0]     s_elapsed_us,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [31:0]       m_speed_rpm,
    output logic                     m_spike_limited,
    output logic                     m_bad_interval,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               cfg_index,
    input  logic [31:0]              cfg_data
);
    import ese_pkg::*;
    logic [30:0] jump_reg;
    logic [16:0] gain_reg;
    logic [15:0] deadband_reg;
    logic q_valid, q_ready, q_bad;
    logic [POSITION_BITS-1:0] q_angle;
    logic [TIME_BITS-1:0] q_dt;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            jump_reg     <= JUMP_RESET;
            gain_reg     <= GAIN_RESET;
            deadband_reg <= DEADBAND_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_JUMP:     jump_reg     <= cfg_data[30:0];
                REG_GAIN:     gain_reg     <= cfg_data[16:0];
                REG_DEADBAND: deadband_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    ese_front #(.POSITION_BITS(POSITION_BITS), .TIME_BITS(TIME_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_angle_code(s_angle_code), .s_elapsed_us(s_elapsed_us),
        .q_valid(q_valid), .q_ready(q_ready),
        .q_angle(q_angle), .q_dt(q_dt), .q_bad(q_bad)
    );

    ese_back #(.POSITION_BITS(POSITION_BITS), .TIME_BITS(TIME_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready),
        .q_angle(q_angle), .q_dt(q_dt), .q_bad(q_bad),
        .max_speed_jump(jump_reg), .filter_gain(gain_reg),
        .zero_deadband(deadband_reg),
        .m_valid(m_valid), .m_ready(m_ready), .m_speed_rpm(m_speed_rpm),
        .m_spike_limited(m_spike_limited), .m_bad_interval(m_bad_interval)
    );
endmodule
